// ===== rtl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Shared types and command codes for the rasterizer core and top level.
// ----------------------------------------------------------------------------
package mer_pkg;

	// Command codes of an input beat
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// Status from the core to the top level
	typedef struct packed {
		logic idle;       // core takes a new beat
		logic res_valid;  // a finished result waits
		logic pix_valid;  // the result carries points
		logic last;       // final point set of the ellipse
	} mer_stat_t;

endpackage

// ===== rtl/mer_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned wide-by-narrow multiply with a registered product, truncated
// to the decision width.
// ----------------------------------------------------------------------------
module mer_mul #(
	parameter int MA = 33,
	parameter int MB = 13,
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic [MA-1:0] op_a,
	input  logic [MB-1:0] op_b,
	output logic [DW-1:0] prod_q
);

	localparam int PW = (MA + MB > DW) ? MA + MB : DW;

	logic [PW-1:0] full;

	// Multiply at full width
	assign full = PW'(op_a) * PW'(op_b);

	// Register the product
	always_ff @(posedge clk) begin
		prod_q <= full[DW-1:0];
	end

endmodule

// ===== rtl/mer_core.sv =====
// ----------------------------------------------------------------------------
// Rasterizer core
// Sequencer and decision datapath of the midpoint ellipse walk. Every
// product goes through one shared registered multiplier.
// ----------------------------------------------------------------------------
module mer_core
	import mer_pkg::*;
#(
	parameter int COORD_BITS = 11,
	parameter int AXIS_BITS  = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  cmd,
	input  logic [COORD_BITS-1:0] cx_in,
	input  logic [COORD_BITS-1:0] cy_in,
	input  logic [AXIS_BITS-1:0]  a_in,
	input  logic [AXIS_BITS-1:0]  b_in,
	input  logic                  res_ready,
	output mer_stat_t             stat,
	output logic [COORD_BITS-1:0] cx,
	output logic [COORD_BITS-1:0] cy,
	output logic [AXIS_BITS:0]    xo,
	output logic [AXIS_BITS-1:0]  yo
);

	localparam int YW = AXIS_BITS;
	localparam int XW = AXIS_BITS + 1;
	localparam int SQ = 2 * AXIS_BITS;
	localparam int MA = 3 * AXIS_BITS + 3;
	localparam int MB = AXIS_BITS + 3;
	localparam int DW = (4 * AXIS_BITS + 8 > 64) ? 64 : 4 * AXIS_BITS + 8;

	// Sequencer states
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SA   = 5'd1;
	localparam logic [4:0] S_SB   = 5'd2;
	localparam logic [4:0] S_SC   = 5'd3;
	localparam logic [4:0] S_SD   = 5'd4;
	localparam logic [4:0] S_TA   = 5'd5;
	localparam logic [4:0] S_TB   = 5'd6;
	localparam logic [4:0] S_TC   = 5'd7;
	localparam logic [4:0] S_R1A  = 5'd8;
	localparam logic [4:0] S_R1B  = 5'd9;
	localparam logic [4:0] S_R1C  = 5'd10;
	localparam logic [4:0] S_EA   = 5'd11;
	localparam logic [4:0] S_EB   = 5'd12;
	localparam logic [4:0] S_EC   = 5'd13;
	localparam logic [4:0] S_ED   = 5'd14;
	localparam logic [4:0] S_EE   = 5'd15;
	localparam logic [4:0] S_R2A  = 5'd16;
	localparam logic [4:0] S_R2B  = 5'd17;
	localparam logic [4:0] S_R2C  = 5'd18;
	localparam logic [4:0] S_DONE = 5'd19;

	logic [4:0]            state_q;
	logic                  busy_q;
	logic                  r2_q;
	logic                  pv_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic [YW-1:0]         a_q;
	logic [YW-1:0]         b_q;
	logic [SQ-1:0]         a2_q;
	logic [SQ-1:0]         b2_q;
	logic [XW-1:0]         x_q;
	logic [YW-1:0]         y_q;
	logic [DW-1:0]         d_q;
	logic [DW-1:0]         t_q;

	logic [MA-1:0] op_a;
	logic [MB-1:0] op_b;
	logic [DW-1:0] p;
	logic [YW-1:0] ym1;
	logic [YW-1:0] b_m_ym1;
	logic [YW:0]   b_p_ym1;
	logic [MB-1:0] tx;
	logic [DW-1:0] a2x4;
	logic          d_pos;

	// Shared multiplier
	mer_mul #(
		.MA(MA),
		.MB(MB),
		.DW(DW)
	) u_mul (
		.clk   (clk),
		.op_a  (op_a),
		.op_b  (op_b),
		.prod_q(p)
	);

	assign ym1     = y_q - YW'(1);
	assign b_m_ym1 = b_q - ym1;
	assign b_p_ym1 = (YW+1)'(b_q) + (YW+1)'(ym1);
	assign tx      = MB'({x_q, 1'b1});
	assign a2x4    = DW'(a2_q) << 2;
	assign d_pos   = !d_q[DW-1] && (d_q != '0);

	// Select multiplier operands by step
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			S_SA: begin
				op_a = MA'(a_q);
				op_b = MB'(a_q);
			end
			S_SB: begin
				op_a = MA'(b_q);
				op_b = MB'(b_q);
			end
			S_SC: begin
				op_a = MA'(a2_q);
				op_b = MB'(b_q);
			end
			S_TA: begin
				op_a = MA'(b2_q);
				op_b = MB'(x_q);
			end
			S_TB: begin
				op_a = MA'(a2_q);
				op_b = MB'(y_q);
			end
			S_R1A: begin
				op_a = MA'(b2_q);
				op_b = tx + MB'(2);
			end
			S_R1B, S_R2A: begin
				op_a = MA'(a2_q);
				op_b = MB'(ym1);
			end
			S_EA: begin
				op_a = MA'(b2_q);
				op_b = tx;
			end
			S_EB: begin
				op_a = MA'(p);
				op_b = tx;
			end
			S_EC: begin
				op_a = MA'(a2_q);
				op_b = MB'(b_m_ym1);
			end
			S_ED: begin
				op_a = MA'(p);
				op_b = MB'(b_p_ym1);
			end
			S_R2B: begin
				op_a = MA'(b2_q);
				op_b = MB'(x_q) + MB'(1);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			r2_q    <= 1'b0;
			pv_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd == CMD_START) begin
							state_q <= S_SA;
							r2_q    <= 1'b0;
						end else if (!busy_q) begin
							state_q <= S_DONE;
							pv_q    <= 1'b0;
						end else if (r2_q) begin
							state_q <= S_R2A;
						end else begin
							state_q <= S_TA;
						end
					end
				end
				S_SA:  state_q <= S_SB;
				S_SB:  state_q <= S_SC;
				S_SC:  state_q <= S_SD;
				S_SD: begin
					state_q <= S_DONE;
					pv_q    <= 1'b1;
				end
				S_TA:  state_q <= S_TB;
				S_TB:  state_q <= S_TC;
				S_TC:  state_q <= (t_q < p) ? S_R1A : S_EA;
				S_R1A: state_q <= S_R1B;
				S_R1B: begin
					if (d_q[DW-1]) begin
						state_q <= S_DONE;
						pv_q    <= 1'b1;
					end else begin
						state_q <= S_R1C;
					end
				end
				S_R1C: begin
					state_q <= S_DONE;
					pv_q    <= 1'b1;
				end
				S_EA:  state_q <= S_EB;
				S_EB:  state_q <= S_EC;
				S_EC:  state_q <= S_ED;
				S_ED:  state_q <= S_EE;
				S_EE: begin
					state_q <= S_R2A;
					r2_q    <= 1'b1;
				end
				S_R2A: state_q <= S_R2B;
				S_R2B: state_q <= S_R2C;
				S_R2C: begin
					state_q <= S_DONE;
					pv_q    <= 1'b1;
				end
				S_DONE: begin
					// Hold until the output register takes the beat
					if (res_ready) begin
						state_q <= S_IDLE;
						if (pv_q) begin
							busy_q <= (y_q != '0);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Decision datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start && cmd == CMD_START) begin
					cx_q <= cx_in;
					cy_q <= cy_in;
					a_q  <= a_in;
					b_q  <= b_in;
				end
			end
			S_SB: a2_q <= p[SQ-1:0];
			S_SC: b2_q <= p[SQ-1:0];
			S_SD: begin
				d_q <= (DW'(b2_q) << 2) - (p << 2) + DW'(a2_q);
				x_q <= '0;
				y_q <= b_q;
			end
			S_TB: t_q <= p;
			S_R1B: begin
				if (d_q[DW-1]) begin
					d_q <= d_q + (p << 2);
					x_q <= x_q + XW'(1);
				end else begin
					t_q <= p;
				end
			end
			S_R1C: begin
				d_q <= d_q + (t_q << 2) - (p << 3);
				x_q <= x_q + XW'(1);
				y_q <= ym1;
			end
			S_EC: t_q <= p;
			S_EE: d_q <= t_q - (p << 2);
			S_R2B: t_q <= p;
			S_R2C: begin
				if (d_pos) begin
					d_q <= d_q + a2x4 - (t_q << 3);
				end else begin
					d_q <= d_q + (p << 3) + a2x4 - (t_q << 3);
					x_q <= x_q + XW'(1);
				end
				y_q <= ym1;
			end
			default: begin
			end
		endcase
	end

	// Status toward the top level
	assign stat.idle      = (state_q == S_IDLE);
	assign stat.res_valid = (state_q == S_DONE);
	assign stat.pix_valid = pv_q;
	assign stat.last      = pv_q && (y_q == '0);

	assign cx = cx_q;
	assign cy = cy_q;
	assign xo = x_q;
	assign yo = y_q;

endmodule

// ===== rtl/midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Emits the four symmetric points of each midpoint step of an ellipse.
// ----------------------------------------------------------------------------
// A start beat (cmd 0) loads center and semi-axes and returns the points of
// offset (0, b); each step beat (cmd 1) advances the decision one step and
// returns the next four points, with last set on the set where y reaches 0.
// A step while no ellipse runs returns an all-zero result. One beat is taken
// at a time, and the products each beat needs go one after another through
// a single registered multiplier. A finished result sits in an output
// register, so the next beat is taken while it waits downstream.
module midpoint_ellipse_rasterizer
	import mer_pkg::*;
#(
	parameter int COORD_BITS = 11,
	parameter int AXIS_BITS  = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [3:0]                   cfg_wdata,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         cmd,
	input  logic [COORD_BITS-1:0]        center_x,
	input  logic [COORD_BITS-1:0]        center_y,
	input  logic [AXIS_BITS-1:0]         semi_x,
	input  logic [AXIS_BITS-1:0]         semi_y,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic                         pixel_valid,
	output logic signed [COORD_BITS+1:0] x_plus,
	output logic signed [COORD_BITS+1:0] x_minus,
	output logic signed [COORD_BITS+1:0] y_plus,
	output logic signed [COORD_BITS+1:0] y_minus,
	output logic [3:0]                   color,
	output logic                         last
);

	localparam int OW = COORD_BITS + 2;
	localparam int SW = (OW > AXIS_BITS + 2) ? OW : AXIS_BITS + 2;
	localparam logic [3:0] COLOR_RST = 4'd2;

	mer_stat_t             stat;
	logic [COORD_BITS-1:0] cx;
	logic [COORD_BITS-1:0] cy;
	logic [AXIS_BITS:0]    xo;
	logic [AXIS_BITS-1:0]  yo;
	logic                  res_ready;
	logic                  take;
	logic [3:0]            color_q;
	logic                  rsp_valid_q;
	logic [SW-1:0]         xp;
	logic [SW-1:0]         xm;
	logic [SW-1:0]         yp;
	logic [SW-1:0]         ym;

	mer_core #(
		.COORD_BITS(COORD_BITS),
		.AXIS_BITS (AXIS_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_valid && !req_stall),
		.cmd      (cmd),
		.cx_in    (center_x),
		.cy_in    (center_y),
		.a_in     (semi_x),
		.b_in     (semi_y),
		.res_ready(res_ready),
		.stat     (stat),
		.cx       (cx),
		.cy       (cy),
		.xo       (xo),
		.yo       (yo)
	);

	assign req_stall = !stat.idle;
	assign res_ready = !rsp_valid_q || !rsp_stall;
	assign take      = stat.res_valid && res_ready;

	// Form the four symmetric coordinates
	assign xp = SW'(cx) + SW'(xo);
	assign xm = SW'(cx) - SW'(xo);
	assign yp = SW'(cy) + SW'(yo);
	assign ym = SW'(cy) - SW'(yo);

	// Hold the color register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RST;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	// Track the output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (take) begin
			pixel_valid <= stat.pix_valid;
			last        <= stat.last;
			if (stat.pix_valid) begin
				x_plus  <= xp[OW-1:0];
				x_minus <= xm[OW-1:0];
				y_plus  <= yp[OW-1:0];
				y_minus <= ym[OW-1:0];
				color   <= color_q;
			end else begin
				x_plus  <= '0;
				x_minus <= '0;
				y_plus  <= '0;
				y_minus <= '0;
				color   <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule
